@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// check only while out of reset
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ hw/rtl/lld_pkg.sv @@
// ----------------------------------------------------------------------------
// lld_pkg
// Shared constants and types of the 3D line-line distance block.
// ----------------------------------------------------------------------------
package lld_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int THR_WIDTH       = 16;
  localparam int MUL_CHUNK       = 32;
  localparam int FIFO_DEPTH_DEF  = 4;

  typedef struct packed {
    logic par;
    logic degen;
  } flags_t;

endpackage

@@ hw/rtl/lld_if.sv @@
// ----------------------------------------------------------------------------
// lld interfaces
// Valid/ready channels for line pairs, distance results and configuration.
// ----------------------------------------------------------------------------
interface lld_in_if #(parameter int CW = lld_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [CW-1:0] p1_x, p1_y, p1_z;
  logic signed [CW-1:0] d1_x, d1_y, d1_z;
  logic signed [CW-1:0] p2_x, p2_y, p2_z;
  logic signed [CW-1:0] d2_x, d2_y, d2_z;

  modport source (output valid, p1_x, p1_y, p1_z, d1_x, d1_y, d1_z,
                  p2_x, p2_y, p2_z, d2_x, d2_y, d2_z, input ready);
  modport sink   (input valid, p1_x, p1_y, p1_z, d1_x, d1_y, d1_z,
                  p2_x, p2_y, p2_z, d2_x, d2_y, d2_z, output ready);
endinterface

interface lld_out_if #(parameter int CW = lld_pkg::COORD_WIDTH_DEF);
  logic          valid;
  logic          ready;
  logic [CW-1:0] distance;
  logic          parallel_path;
  logic          degenerate;

  modport source (output valid, distance, parallel_path, degenerate, input ready);
  modport sink   (input valid, distance, parallel_path, degenerate, output ready);
endinterface

interface lld_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lld_pkg::THR_WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/line_line_distance_3d.sv @@
// ----------------------------------------------------------------------------
// line_line_distance_3d
// Shortest distance between two 3D lines in signed fixed point.
// ----------------------------------------------------------------------------
// Use: present a line pair (point and direction of each line) on in_i; it is
// taken when valid and ready are both high. One result per pair leaves on
// out_o in the same order, with distance saturated at all ones and flags for
// the parallel formula and a zero first direction.
// Throughput: one pair per cycle while out_o does not stall, set by the
// fully pipelined multipliers, the one-bit-per-stage divider and the
// two-bits-per-stage square root. From acceptance to out_o valid a pair
// passes 13 front stages, one queue slot, one overflow stage,
// 2*COORD_WIDTH divide stages, COORD_WIDTH root stages and the result.
// cfg_i writes parallel_threshold; it is always ready. The user must see that
// it is written only while no pair is in flight; the block does not enforce it.
// Reset clears all valid flags and the threshold; no clearing pass follows.
// When out_o stalls, the back pipeline holds, the queue fills, then the front
// holds and in_i.ready drops.
// ----------------------------------------------------------------------------
module line_line_distance_3d #(
  parameter int COORD_WIDTH = lld_pkg::COORD_WIDTH_DEF,
  parameter int FIFO_DEPTH  = lld_pkg::FIFO_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lld_cfg_if.sink  cfg_i,
  lld_in_if.sink   in_i,
  lld_out_if.source out_o
);
  import lld_pkg::*;

  localparam int NW = 6*COORD_WIDTH + 2;
  localparam int DW = 4*COORD_WIDTH;
  localparam int QDW = NW + DW + $bits(flags_t);

  logic [THR_WIDTH-1:0]          thr_q;
  logic signed [COORD_WIDTH-1:0] p1 [3];
  logic signed [COORD_WIDTH-1:0] d1 [3];
  logic signed [COORD_WIDTH-1:0] p2 [3];
  logic signed [COORD_WIDTH-1:0] d2 [3];

  logic          f_valid, f_ready;
  logic [NW-1:0] f_num;
  logic [DW-1:0] f_den;
  flags_t        f_flags;
  logic          b_valid, b_ready;
  logic [QDW-1:0] b_data;
  logic [NW-1:0] b_num;
  logic [DW-1:0] b_den;
  flags_t        b_flags;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      thr_q <= cfg_i.data;
    end
  end

  assign p1[0] = in_i.p1_x;
  assign p1[1] = in_i.p1_y;
  assign p1[2] = in_i.p1_z;
  assign d1[0] = in_i.d1_x;
  assign d1[1] = in_i.d1_y;
  assign d1[2] = in_i.d1_z;
  assign p2[0] = in_i.p2_x;
  assign p2[1] = in_i.p2_y;
  assign p2[2] = in_i.p2_z;
  assign d2[0] = in_i.d2_x;
  assign d2[1] = in_i.d2_y;
  assign d2[2] = in_i.d2_z;

  lld_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .p1_i        (p1),
    .d1_i        (d1),
    .p2_i        (p2),
    .d2_i        (d2),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .num_o       (f_num),
    .den_o       (f_den),
    .flags_o     (f_flags)
  );

  lld_fifo #(.W(QDW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   ({f_num, f_den, f_flags}),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_data)
  );

  assign {b_num, b_den, b_flags} = b_data;

  lld_back #(.CW(COORD_WIDTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (b_valid),
    .in_ready_o      (b_ready),
    .num_i           (b_num),
    .den_i           (b_den),
    .flags_i         (b_flags),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .distance_o      (out_o.distance),
    .parallel_path_o (out_o.parallel_path),
    .degenerate_o    (out_o.degenerate)
  );

endmodule

@@ hw/rtl/lld_mul.sv @@
// ----------------------------------------------------------------------------
// lld_mul
// Signed multiplier from 32x32 partial products, three register stages.
// ----------------------------------------------------------------------------
module lld_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import lld_pkg::*;

  localparam int C  = MUL_CHUNK;
  localparam int NA = (WA + C - 1) / C;
  localparam int NB = (WB + C - 1) / C;
  localparam int PW = (NA + NB) * C;

  logic [WA-1:0]   abs_a;
  logic [WB-1:0]   abs_b;
  logic [NA*C-1:0] ma;
  logic [NB*C-1:0] mb;
  logic [2*C-1:0]  pp_q [NA][NB];
  logic [PW-1:0]   row_d [NA];
  logic [PW-1:0]   row_q [NA];
  logic [PW-1:0]   acc;
  logic            neg1_q, neg2_q;

  always_comb begin
    abs_a = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
    abs_b = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);
    ma    = (NA*C)'(abs_a);
    mb    = (NB*C)'(abs_b);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ma[i*C +: C] * mb[j*C +: C];
        end
      end
      neg1_q <= a_i[WA-1] ^ b_i[WB-1];
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (PW'(pp_q[i][j]) << (j*C));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q  <= row_d;
      neg2_q <= neg1_q;
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      acc = acc + (row_q[i] << (i*C));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= neg2_q ? -$signed(acc[WA+WB-1:0]) : $signed(acc[WA+WB-1:0]);
    end
  end

endmodule

@@ hw/rtl/lld_front.sv @@
// ----------------------------------------------------------------------------
// lld_front
// Forms cross products and dot products, classifies the pair as parallel or
// skew, and hands numerator, denominator and flags to the queue.
// ----------------------------------------------------------------------------
module lld_front #(
  parameter int CW = lld_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lld_pkg::THR_WIDTH-1:0]  thr_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [CW-1:0]           p1_i [3],
  input  logic signed [CW-1:0]           d1_i [3],
  input  logic signed [CW-1:0]           p2_i [3],
  input  logic signed [CW-1:0]           d2_i [3],
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [6*CW+1:0]                num_o,
  output logic [4*CW-1:0]                den_o,
  output lld_pkg::flags_t                flags_o
);
  import lld_pkg::*;

  localparam int GW  = CW + 1;
  localparam int NCW = 2*CW + 1;
  localparam int CCW = 2*CW + 2;
  localparam int AAW = 2*CW;
  localparam int NNW = 4*CW;
  localparam int CSW = 4*CW + 2;
  localparam int SW  = 3*CW + 2;
  localparam int NW  = 6*CW + 2;
  localparam int DW  = 4*CW;
  localparam int NST = 13;

  logic [NST-1:0] vld_q;
  logic           en;

  logic signed [CW-1:0]    a_q [3];
  logic signed [CW-1:0]    b_q [3];
  logic signed [GW-1:0]    g_q [3];
  logic signed [GW-1:0]    gd_q [4][3];
  logic signed [2*CW-1:0]  pnl [3];
  logic signed [2*CW-1:0]  pnr [3];
  logic signed [2*CW:0]    pcl [3];
  logic signed [2*CW:0]    pcr [3];
  logic signed [2*CW-1:0]  paa [3];
  logic signed [NCW-1:0]   n_q [3];
  logic signed [CCW-1:0]   c_q [3];
  logic [AAW-1:0]          aa_q;
  logic [AAW-1:0]          ad_q [4];
  logic signed [2*NCW-1:0] nsq [3];
  logic signed [2*CCW-1:0] csq [3];
  logic signed [SW-1:0]    gn [3];
  logic [NNW-1:0]          nn_q;
  logic [CSW-1:0]          cc_q;
  logic signed [SW-1:0]    s_q;
  logic signed [2*SW-1:0]  pss;
  logic [CSW-1:0]          ccd_q [3];
  logic [DW-1:0]           dd_q [3];
  flags_t                  fl_q [3];
  flags_t                  fl_d;
  logic [DW-1:0]           den_d;
  logic [NW-1:0]           num_q;
  logic [DW-1:0]           den_q;
  flags_t                  flags_q;

  assign en          = !(vld_q[NST-1] && !out_ready_i);
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];
  assign num_o       = num_q;
  assign den_o       = den_q;
  assign flags_o     = flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_q[i] <= d1_i[i];
        b_q[i] <= d2_i[i];
        g_q[i] <= GW'(p2_i[i]) - GW'(p1_i[i]);
      end
      gd_q[0] <= g_q;
      for (int k = 1; k < 4; k++) gd_q[k] <= gd_q[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_m1
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    lld_mul #(.WA(CW), .WB(CW)) u_nl (
      .clk_i(clk_i), .en_i(en), .a_i(a_q[J]), .b_i(b_q[K]), .p_o(pnl[i]));
    lld_mul #(.WA(CW), .WB(CW)) u_nr (
      .clk_i(clk_i), .en_i(en), .a_i(a_q[K]), .b_i(b_q[J]), .p_o(pnr[i]));
    lld_mul #(.WA(GW), .WB(CW)) u_cl (
      .clk_i(clk_i), .en_i(en), .a_i(g_q[J]), .b_i(a_q[K]), .p_o(pcl[i]));
    lld_mul #(.WA(GW), .WB(CW)) u_cr (
      .clk_i(clk_i), .en_i(en), .a_i(g_q[K]), .b_i(a_q[J]), .p_o(pcr[i]));
    lld_mul #(.WA(CW), .WB(CW)) u_aa (
      .clk_i(clk_i), .en_i(en), .a_i(a_q[i]), .b_i(a_q[i]), .p_o(paa[i]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= NCW'(pnl[i]) - NCW'(pnr[i]);
        c_q[i] <= CCW'(pcl[i]) - CCW'(pcr[i]);
      end
      aa_q    <= AAW'(paa[0]) + AAW'(paa[1]) + AAW'(paa[2]);
      ad_q[0] <= aa_q;
      for (int k = 1; k < 4; k++) ad_q[k] <= ad_q[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_m2
    lld_mul #(.WA(NCW), .WB(NCW)) u_nsq (
      .clk_i(clk_i), .en_i(en), .a_i(n_q[i]), .b_i(n_q[i]), .p_o(nsq[i]));
    lld_mul #(.WA(CCW), .WB(CCW)) u_csq (
      .clk_i(clk_i), .en_i(en), .a_i(c_q[i]), .b_i(c_q[i]), .p_o(csq[i]));
    lld_mul #(.WA(GW), .WB(NCW)) u_gn (
      .clk_i(clk_i), .en_i(en), .a_i(gd_q[3][i]), .b_i(n_q[i]), .p_o(gn[i]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nn_q <= NNW'(nsq[0]) + NNW'(nsq[1]) + NNW'(nsq[2]);
      cc_q <= CSW'(csq[0]) + CSW'(csq[1]) + CSW'(csq[2]);
      s_q  <= gn[0] + gn[1] + gn[2];
    end
  end

  lld_mul #(.WA(SW), .WB(SW)) u_ss (
    .clk_i(clk_i), .en_i(en), .a_i(s_q), .b_i(s_q), .p_o(pss));

  always_comb begin
    fl_d.par   = nn_q <= NNW'(thr_i);
    fl_d.degen = fl_d.par && (ad_q[3] == '0);
    if (!fl_d.par) begin
      den_d = nn_q;
    end else if (fl_d.degen) begin
      den_d = DW'(1'b1);
    end else begin
      den_d = DW'(ad_q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ccd_q[0] <= cc_q;
      dd_q[0]  <= den_d;
      fl_q[0]  <= fl_d;
      for (int k = 1; k < 3; k++) begin
        ccd_q[k] <= ccd_q[k-1];
        dd_q[k]  <= dd_q[k-1];
        fl_q[k]  <= fl_q[k-1];
      end
      if (fl_q[2].degen) begin
        num_q <= '0;
      end else if (fl_q[2].par) begin
        num_q <= NW'(ccd_q[2]);
      end else begin
        num_q <= pss[NW-1:0];
      end
      den_q   <= dd_q[2];
      flags_q <= fl_q[2];
    end
  end

endmodule

@@ hw/rtl/lld_fifo.sv @@
// ----------------------------------------------------------------------------
// lld_fifo
// Short queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module lld_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = lld_pkg::FIFO_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);
  localparam int AW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_q [DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CNW-1:0] cnt_q;
  logic           push, pop;

  assign in_ready_o  = cnt_q != CNW'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

endmodule

@@ hw/rtl/lld_back.sv @@
// ----------------------------------------------------------------------------
// lld_back
// Pipelined restoring divide and square root, saturation and result register.
// ----------------------------------------------------------------------------
module lld_back #(
  parameter int CW = lld_pkg::COORD_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [6*CW+1:0]  num_i,
  input  logic [4*CW-1:0]  den_i,
  input  lld_pkg::flags_t  flags_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CW-1:0]    distance_o,
  output logic             parallel_path_o,
  output logic             degenerate_o
);
  import lld_pkg::*;

  localparam int NW  = 6*CW + 2;
  localparam int DW  = 4*CW;
  localparam int QW  = 2*CW;
  localparam int HW  = NW - QW;
  localparam int RW  = CW + 2;
  localparam int NST = QW + CW + 2;

  logic [NST-1:0] vld_q;
  logic           en;

  logic [DW-1:0]  rem_q [QW+1];
  logic [QW-1:0]  lo_q  [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic [DW-1:0]  den_q [QW+1];
  logic           dovf_q [QW+1];
  flags_t         dfl_q [QW+1];

  logic [RW-1:0]  srem [CW+1];
  logic [CW-1:0]  root [CW+1];
  logic [QW-1:0]  sval [CW+1];
  logic           sovf [CW+1];
  flags_t         sfl  [CW+1];

  logic [CW-1:0]  dist_q;
  flags_t         ofl_q;

  assign en              = !(vld_q[NST-1] && !out_ready_i);
  assign in_ready_o      = en;
  assign out_valid_o     = vld_q[NST-1];
  assign distance_o      = dist_q;
  assign parallel_path_o = ofl_q.par;
  assign degenerate_o    = ofl_q.degen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dovf_q[0] <= num_i[NW-1:QW] >= HW'(den_i);
      rem_q[0]  <= num_i[QW+DW-1:QW];
      lo_q[0]   <= num_i[QW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      dfl_q[0]  <= flags_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] r2;
    logic        ge;
    always_comb begin
      r2 = {rem_q[k], lo_q[k][QW-1]};
      ge = r2 >= {1'b0, den_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1]  <= ge ? DW'(r2 - {1'b0, den_q[k]}) : r2[DW-1:0];
        lo_q[k+1]   <= lo_q[k] << 1;
        quo_q[k+1]  <= {quo_q[k][QW-2:0], ge};
        den_q[k+1]  <= den_q[k];
        dovf_q[k+1] <= dovf_q[k];
        dfl_q[k+1]  <= dfl_q[k];
      end
    end
  end

  assign srem[0] = '0;
  assign root[0] = '0;
  assign sval[0] = quo_q[QW];
  assign sovf[0] = dovf_q[QW];
  assign sfl[0]  = dfl_q[QW];

  for (genvar j = 0; j < CW; j++) begin : g_sqrt
    logic [RW-1:0] rin;
    logic [RW-1:0] trial;
    logic          ge;
    always_comb begin
      rin   = {srem[j][CW-1:0], sval[j][QW-1:QW-2]};
      trial = {root[j], 2'b01};
      ge    = rin >= trial;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        srem[j+1] <= ge ? rin - trial : rin;
        root[j+1] <= {root[j][CW-2:0], ge};
        sval[j+1] <= sval[j] << 2;
        sovf[j+1] <= sovf[j];
        sfl[j+1]  <= sfl[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= sovf[CW] ? '1 : root[CW];
      ofl_q  <= sfl[CW];
    end
  end

endmodule

@@ hw/rtl/lld_checker.sv @@
// ----------------------------------------------------------------------------
// lld_checker
// Port-level checks of the line-line distance block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lld_checker #(
  parameter int CW = lld_pkg::COORD_WIDTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [CW-1:0] distance_i,
  input logic          parallel_path_i,
  input logic          degenerate_i
);
  localparam int CNTW = $clog2(3*CW + 64);

  logic [CNTW-1:0] cnt_q;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  `ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_valid_i, "result valid in reset")
  `ASSERT_RUN(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_i) && $stable(parallel_path_i) && $stable(degenerate_i), "stalled result changed")
  `ASSERT_RUN(a_no_spurious, clk_i, rst_ni, out_valid_i |-> cnt_q != '0, "result without item")
  `ASSERT_RUN(a_degen, clk_i, rst_ni, out_valid_i && degenerate_i |-> parallel_path_i && distance_i == '0, "bad degenerate result")

endmodule

bind line_line_distance_3d lld_checker #(.CW(COORD_WIDTH)) u_lld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .distance_i      (out_o.distance),
  .parallel_path_i (out_o.parallel_path),
  .degenerate_i    (out_o.degenerate)
);
